// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HTD_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define HTD_ASSERT(lbl, prop) \
  `HTD_ASSERT_MSG(lbl, prop, "htd assertion failed")

`endif

// ===== hw/rtl/htd_pkg.sv =====
package htd_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned HandleReach     = 64;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_PROBE  = 2'd1,
    OP_COMMIT = 2'd2
  } op_e;

  typedef struct packed {
    act_e       action;
    logic [5:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [5:0] handle_out;
    logic [5:0] dense_index;
    logic [6:0] item_count;
    status_e    status;
  } res_t;

  // item travelling down the cell chain
  typedef struct packed {
    logic       vld;
    op_e        op;
    logic [5:0] handle;
    logic [5:0] pos;
    logic       found;
    logic [5:0] fhandle;
    logic [5:0] fpos;
  } token_t;

endpackage

// ===== hw/rtl/htd_cell.sv =====
module htd_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  htd_pkg::token_t tok_i,
  output htd_pkg::token_t tok_o
);

  logic            valid_q, valid_d;
  logic [5:0]      pos_q, pos_d;
  htd_pkg::token_t tok_q, tok_d;
  logic            hit;

  assign hit = (tok_i.handle == 6'(IDX));

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    pos_d   = pos_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        htd_pkg::OP_ADD: begin
          if (!tok_i.found && !valid_q) begin
            valid_d       = 1'b1;
            pos_d         = tok_i.pos;
            tok_d.found   = 1'b1;
            tok_d.fhandle = 6'(IDX);
          end
        end
        htd_pkg::OP_PROBE: begin
          if (hit && valid_q) begin
            tok_d.found = 1'b1;
            tok_d.fpos  = pos_q;
          end
        end
        htd_pkg::OP_COMMIT: begin
          if (hit) begin
            valid_d = 1'b0;
            pos_d   = '0;
          end else if (valid_q && (pos_q > tok_i.pos)) begin
            pos_d = pos_q - 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/htd_ctrl.sv =====
module htd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  htd_pkg::cmd_t   cmd_i,
  input  htd_pkg::token_t tail_i,
  output htd_pkg::token_t inj_o,
  output logic            busy,
  output logic            strobe_o,
  output htd_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e          state_q, state_d;
  htd_pkg::act_e   act_q, act_d;
  logic [5:0]      hdl_q, hdl_d;
  logic [6:0]      count_q, count_d;
  htd_pkg::token_t inj_q, inj_d;
  htd_pkg::res_t   res_q, res_d;
  logic            strobe_q, strobe_d;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    hdl_d    = hdl_q;
    count_d  = count_q;
    inj_d    = '0;
    res_d    = res_q;
    strobe_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d        = cmd_i.action;
          hdl_d        = cmd_i.handle;
          inj_d.vld    = 1'b1;
          inj_d.op     = (cmd_i.action == htd_pkg::ACT_ADD) ? htd_pkg::OP_ADD
                                                             : htd_pkg::OP_PROBE;
          inj_d.handle = cmd_i.handle;
          inj_d.pos    = count_q[5:0];
          state_d      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (tail_i.vld) begin
          strobe_d          = 1'b1;
          state_d           = ST_IDLE;
          res_d.handle_out  = hdl_q;
          res_d.dense_index = '0;
          res_d.status      = htd_pkg::STAT_BAD;
          case (act_q)
            htd_pkg::ACT_ADD: begin
              if (tail_i.found) begin
                res_d.handle_out  = tail_i.fhandle;
                res_d.dense_index = count_q[5:0];
                res_d.status      = htd_pkg::STAT_OK;
                count_d           = count_q + 7'd1;
              end else begin
                res_d.handle_out = '0;
                res_d.status     = htd_pkg::STAT_FULL;
              end
            end
            htd_pkg::ACT_REMOVE: begin
              if (tail_i.found) begin
                strobe_d     = 1'b0;
                state_d      = ST_COMMIT;
                inj_d.vld    = 1'b1;
                inj_d.op     = htd_pkg::OP_COMMIT;
                inj_d.handle = hdl_q;
                inj_d.pos    = tail_i.fpos;
              end
            end
            htd_pkg::ACT_LOOKUP: begin
              if (tail_i.found) begin
                res_d.dense_index = tail_i.fpos;
                res_d.status      = htd_pkg::STAT_OK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_COMMIT: begin
        if (tail_i.vld) begin
          strobe_d          = 1'b1;
          state_d           = ST_IDLE;
          res_d.handle_out  = hdl_q;
          res_d.dense_index = tail_i.pos;
          res_d.status      = htd_pkg::STAT_OK;
          if (count_q != 7'd0) begin
            count_d = count_q - 7'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    res_d.item_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      inj_q    <= '0;
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      inj_q    <= inj_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    hdl_q <= hdl_d;
  end

  assign inj_o    = inj_q;
  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ===== hw/rtl/handle_to_dense_index_table.sv =====
// channel   dir  handshake          payload
// command   in   start && !busy     cmd_i  (action, handle)
// result    out  strobe_o, 1 cycle  res_o  (handle_out, dense_index, item_count, status)
//
// One cell per usable handle, min(CAPACITY, 64) cells; an item walks the chain one cell
// per cycle. Add and lookup take one pass down the chain; a remove of a mapped handle
// takes a probe pass and a commit pass. busy stays high until the result strobe.
// Reset clears every mapping and the live count; the table is usable right after reset.
// Results cannot be stalled; strobe_o is high for one cycle per item.
`include "assert_macros.svh"

module handle_to_dense_index_table #(
  parameter int unsigned CAPACITY = htd_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  htd_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          strobe_o,
  output htd_pkg::res_t res_o
);

  localparam int unsigned NCELL = (CAPACITY < htd_pkg::HandleReach) ? CAPACITY
                                                                    : htd_pkg::HandleReach;

  htd_pkg::token_t tok [NCELL+1];
  logic            res_full;

  htd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .tail_i   (tok[NCELL]),
    .inj_o    (tok[0]),
    .busy     (busy),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    htd_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign res_full = strobe_o && (res_o.status == htd_pkg::STAT_FULL);

  `HTD_ASSERT(a_count_bound, strobe_o |-> (res_o.item_count <= 7'(NCELL)))
  `HTD_ASSERT(a_full_count, res_full |-> (res_o.item_count == 7'(NCELL)))
  `HTD_ASSERT(a_busy_after_start, (start && !busy) |=> busy)
  `HTD_ASSERT_MSG(a_idle_at_strobe, strobe_o |-> !busy, "result while still busy")

endmodule
